@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during the reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sese_pkg.sv @@
// ----------------------------------------------------------------------------
// sese_pkg
// Shared constants of the signed edge swap engine: operation codes, status
// codes, register map and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package sese_pkg;

   // Default sizes of the weight matrix.
   localparam int MAX_NODES_DEF   = 64;
   localparam int WEIGHT_BITS_DEF = 32;

   // Fixed field widths of the item interfaces.
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int NC_W     = 7;
   localparam int CSR_AW   = 3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_SWAP  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DISTINCT = 2'd2;

   // Register map: word index taken from paddr[2].
   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic [NC_W-1:0] NODE_COUNT_RESET = 7'd64;

endpackage

`default_nettype wire

@@ rtl/signed_edge_swap_engine.sv @@
// ----------------------------------------------------------------------------
// signed_edge_swap_engine
// Signed weight matrix with entry load, read back and degree
// preserving swap attempts on four nodes.
// ----------------------------------------------------------------------------
// The matrix lives in one RAM with a single write port and a single read
// port, addressed row*MAX_NODES+col, and one item is worked on at a time.
// A write stores one entry, a read fetches one, a rejected item touches
// none, a swap attempt reads four entries and an applied swap writes
// eight through the one write port. A new item is taken while the previous
// result still waits in the output register. Entries must be written before
// they are read or swapped; the RAM has no reset.
`default_nettype none

module signed_edge_swap_engine
   import sese_pkg::*;
#(
   parameter int MAX_NODES   = MAX_NODES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic        [OP_W-1:0]         req_op,
   input  wire logic        [$clog2(MAX_NODES)-1:0] req_row,
   input  wire logic        [$clog2(MAX_NODES)-1:0] req_col,
   input  wire logic signed [DATA_W-1:0]       req_value,
   input  wire logic        [$clog2(MAX_NODES)-1:0] req_node_a,
   input  wire logic        [$clog2(MAX_NODES)-1:0] req_node_b,
   input  wire logic        [$clog2(MAX_NODES)-1:0] req_node_c,
   input  wire logic        [$clog2(MAX_NODES)-1:0] req_node_d,
   // Response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed      [DATA_W-1:0]       rsp_read_value,
   output logic                                rsp_swapped,
   output logic             [STATUS_W-1:0]     rsp_status,
   // Configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic        [CSR_AW-1:0]       csr_paddr,
   input  wire logic        [DATA_W-1:0]       csr_pwdata,
   output logic             [DATA_W-1:0]       csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int DEPTH  = MAX_NODES * MAX_NODES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W  = (IDX_W + 1 > NC_W) ? IDX_W + 1 : NC_W;

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_WR     = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_RDCAP  = 4'd3;
   localparam logic [3:0] S_SWRD   = 4'd4;
   localparam logic [3:0] S_SWLAST = 4'd5;
   localparam logic [3:0] S_EVAL   = 4'd6;
   localparam logic [3:0] S_SWWR   = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;

   // Sign class of a weight: {negative, nonzero}.
   function automatic logic [1:0] sign_class(input logic [WEIGHT_BITS-1:0] w);
      return {w[WEIGHT_BITS-1], (w != '0)};
   endfunction

   // Control registers.
   logic [3:0]      state_ff, state_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [NC_W-1:0] node_count_ff;
   logic            rsp_valid_ff;

   // Item registers.
   logic [OP_W-1:0]          op_ff;
   logic [IDX_W-1:0]         row_ff, col_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [IDX_W-1:0]         a_ff, b_ff, c_ff, d_ff;
   logic [WEIGHT_BITS-1:0]   w_ff [4];

   // Pending result and output registers.
   logic signed [DATA_W-1:0] res_value_ff;
   logic                     res_swapped_ff;
   logic [STATUS_W-1:0]      res_status_ff;
   logic signed [DATA_W-1:0] rsp_read_value_ff;
   logic                     rsp_swapped_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;

   // RAM interface.
   logic                          mem_we, mem_re;
   logic [ADDR_W-1:0]             mem_addr;
   logic [WEIGHT_BITS-1:0]        mem_wdata;
   logic signed [WEIGHT_BITS-1:0] mem_rdata;
   logic [IDX_W-1:0]              sel_row, sel_col;

   logic req_fire, out_free, csr_write, swap_ok;
   logic [CMP_W-1:0]    limit;
   logic                rc_in_range, sw_in_range, sw_distinct;
   logic [STATUS_W-1:0] status_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register read back.
   assign csr_prdata = (csr_paddr[2] == REG_NODE_COUNT) ? DATA_W'(node_count_ff) : '0;

   // Index checks on the incoming item; node_count is capped at MAX_NODES.
   always_comb begin
      limit = (CMP_W'(node_count_ff) > CMP_W'(MAX_NODES)) ?
              CMP_W'(MAX_NODES) : CMP_W'(node_count_ff);
      rc_in_range = (CMP_W'(req_row) < limit) && (CMP_W'(req_col) < limit);
      sw_in_range = (CMP_W'(req_node_a) < limit) && (CMP_W'(req_node_b) < limit) &&
                    (CMP_W'(req_node_c) < limit) && (CMP_W'(req_node_d) < limit);
      sw_distinct = (req_node_a != req_node_b) && (req_node_a != req_node_c) &&
                    (req_node_a != req_node_d) && (req_node_b != req_node_c) &&
                    (req_node_b != req_node_d) && (req_node_c != req_node_d);
      case (req_op)
         OP_WRITE, OP_READ: begin
            status_in = rc_in_range ? ST_OK : ST_RANGE;
         end
         OP_SWAP: begin
            if (!sw_in_range) begin
               status_in = ST_RANGE;
            end else if (!sw_distinct) begin
               status_in = ST_DISTINCT;
            end else begin
               status_in = ST_OK;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Sign rule on the four weights gathered for a swap.
   assign swap_ok = (sign_class(w_ff[0]) == sign_class(w_ff[1])) &&
                    (sign_class(w_ff[2]) == sign_class(w_ff[3])) &&
                    (sign_class(w_ff[0]) != sign_class(w_ff[2]));

   // RAM address, data and strobes for each sequencer step.
   // Read order: (a,b) (c,d) (a,d) (c,b); w_ff keeps them in that order.
   always_comb begin
      sel_row   = row_ff;
      sel_col   = col_ff;
      mem_wdata = WEIGHT_BITS'(value_ff);
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      case (state_ff)
         S_WR: begin
            mem_we = 1'b1;
         end
         S_RD: begin
            mem_re = 1'b1;
         end
         S_SWRD: begin
            mem_re = 1'b1;
            case (cnt_ff[1:0])
               2'd0:    begin sel_row = a_ff; sel_col = b_ff; end
               2'd1:    begin sel_row = c_ff; sel_col = d_ff; end
               2'd2:    begin sel_row = a_ff; sel_col = d_ff; end
               default: begin sel_row = c_ff; sel_col = b_ff; end
            endcase
         end
         S_SWWR: begin
            mem_we = 1'b1;
            case (cnt_ff)
               3'd0:    begin sel_row = a_ff; sel_col = d_ff; mem_wdata = w_ff[0]; end
               3'd1:    begin sel_row = d_ff; sel_col = a_ff; mem_wdata = w_ff[0]; end
               3'd2:    begin sel_row = a_ff; sel_col = b_ff; mem_wdata = w_ff[2]; end
               3'd3:    begin sel_row = b_ff; sel_col = a_ff; mem_wdata = w_ff[2]; end
               3'd4:    begin sel_row = c_ff; sel_col = b_ff; mem_wdata = w_ff[1]; end
               3'd5:    begin sel_row = b_ff; sel_col = c_ff; mem_wdata = w_ff[1]; end
               3'd6:    begin sel_row = c_ff; sel_col = d_ff; mem_wdata = w_ff[3]; end
               default: begin sel_row = d_ff; sel_col = c_ff; mem_wdata = w_ff[3]; end
            endcase
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      mem_addr = ADDR_W'(ADDR_W'(sel_row) * ADDR_W'(MAX_NODES)) + ADDR_W'(sel_col);
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_fire) begin
               if (status_in != ST_OK) begin
                  state_in = S_FIN;
               end else begin
                  case (req_op)
                     OP_WRITE: state_in = S_WR;
                     OP_READ:  state_in = S_RD;
                     OP_SWAP:  state_in = S_SWRD;
                     default:  state_in = S_FIN;
                  endcase
               end
            end
         end
         S_WR: begin
            state_in = S_FIN;
         end
         S_RD: begin
            state_in = S_RDCAP;
         end
         S_RDCAP: begin
            state_in = S_FIN;
         end
         S_SWRD: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = S_SWLAST;
            end
         end
         S_SWLAST: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cnt_in   = '0;
            state_in = swap_ok ? S_SWWR : S_FIN;
         end
         S_SWWR: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write && (csr_paddr[2] == REG_NODE_COUNT)) begin
            node_count_ff <= csr_pwdata[NC_W-1:0];
         end
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item capture, gathered weights and result.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff          <= req_op;
         row_ff         <= req_row;
         col_ff         <= req_col;
         value_ff       <= req_value;
         a_ff           <= req_node_a;
         b_ff           <= req_node_b;
         c_ff           <= req_node_c;
         d_ff           <= req_node_d;
         res_value_ff   <= '0;
         res_swapped_ff <= 1'b0;
         res_status_ff  <= status_in;
      end
      // Read data arrives in the cycle after its address.
      if (state_ff == S_SWRD && cnt_ff[1:0] != 2'd0) begin
         w_ff[cnt_ff[1:0] - 2'd1] <= mem_rdata;
      end
      if (state_ff == S_SWLAST) begin
         w_ff[3] <= mem_rdata;
      end
      if (state_ff == S_RDCAP && op_ff == OP_READ) begin
         res_value_ff <= DATA_W'(mem_rdata);
      end
      if (state_ff == S_EVAL) begin
         res_swapped_ff <= swap_ok;
      end
      // Output register.
      if (state_ff == S_FIN && out_free) begin
         rsp_read_value_ff <= res_value_ff;
         rsp_swapped_ff    <= res_swapped_ff;
         rsp_status_ff     <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_swapped    = rsp_swapped_ff;
   assign rsp_status     = rsp_status_ff;

   // Weight matrix storage.
   sese_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/sese_ram.sv @@
// ----------------------------------------------------------------------------
// sese_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sese_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/sese_checker.sv @@
// ----------------------------------------------------------------------------
// sese_checker
// Port-level assertions for the signed edge swap engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sese_checker
   import sese_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [DATA_W-1:0]   rsp_read_value,
   input wire logic                rsp_swapped,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                csr_pready
);

   // No result is offered right after reset.
   `ASSERT_CLK(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result offered after reset")

   // A reported swap always carries an ok status.
   `ASSERT_CLK_RST(a_swap_ok, clock, reset, (rsp_valid && rsp_swapped) |-> (rsp_status == ST_OK), "swap reported with error status")

   // A rejected item changes nothing and reads back zero.
   `ASSERT_CLK_RST(a_reject_clean, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> (!rsp_swapped && rsp_read_value == '0), "rejected item has nonzero fields")

   // A stalled result holds.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_value) && $stable(rsp_status)), "stalled result changed")

   // The configuration port never waits.
   `ASSERT_CLK_RST(a_pready, clock, reset, csr_pready, "csr_pready low")

endmodule

bind signed_edge_swap_engine sese_checker u_sese_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_swapped    (rsp_swapped),
   .rsp_status     (rsp_status),
   .csr_pready     (csr_pready)
);

`default_nettype wire
